// ----- rtl/core/cslex_pkg.sv -----
// ----------------------------------------------------------------------------
// C source lexer statistics package
// Shared types, character constants and keyword tables for the byte-stream
// C lexer that keeps running source statistics.
// ----------------------------------------------------------------------------
package cslex_pkg;

  // Width of the internal saturating counters. Results carry the low 32 bits.
  localparam int unsigned COUNT_WIDTH = 32;
  localparam int unsigned OUT_WIDTH   = 32;

  typedef logic [COUNT_WIDTH-1:0] count_t;

  typedef enum logic [2:0] {
    MODE_TOP    = 3'd0,
    MODE_SLASH  = 3'd1,
    MODE_STRING = 3'd2,
    MODE_LINE   = 3'd3,
    MODE_BLOCK  = 3'd4,
    MODE_IDENT  = 3'd5,
    MODE_NUMBER = 3'd6
  } lex_mode_e;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  localparam logic [7:0] UTF8_MASK2 = 8'hE0;
  localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
  localparam logic [7:0] UTF8_MASK3 = 8'hF0;
  localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
  localparam logic [7:0] UTF8_MASK4 = 8'hF8;
  localparam logic [7:0] UTF8_LEAD4 = 8'hF0;

  localparam logic [2:0] PRINTF_LEN = 3'd6;
  localparam logic [2:0] SCANF_LEN  = 3'd5;
  localparam logic [2:0] IDENT_MAX  = 3'd7;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_marker;
  } in_item_t;

  typedef struct packed {
    logic [OUT_WIDTH-1:0] line_count;
    logic [OUT_WIDTH-1:0] char_count;
    logic [OUT_WIDTH-1:0] space_count;
    logic [OUT_WIDTH-1:0] printf_count;
    logic [OUT_WIDTH-1:0] scanf_count;
    logic [OUT_WIDTH-1:0] comment_count;
    logic                 done_res;
  } out_item_t;

  function automatic logic [7:0] printf_char(input logic [2:0] pos);
    logic [7:0] ch;
    unique case (pos)
      3'd0:    ch = 8'h70; // p
      3'd1:    ch = 8'h72; // r
      3'd2:    ch = 8'h69; // i
      3'd3:    ch = 8'h6E; // n
      3'd4:    ch = 8'h74; // t
      3'd5:    ch = 8'h66; // f
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] scanf_char(input logic [2:0] pos);
    logic [7:0] ch;
    unique case (pos)
      3'd0:    ch = 8'h73; // s
      3'd1:    ch = 8'h63; // c
      3'd2:    ch = 8'h61; // a
      3'd3:    ch = 8'h6E; // n
      3'd4:    ch = 8'h66; // f
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic count_t sat_inc(input count_t v, input logic en);
    count_t r;
    r = v;
    if (en && (v != '1)) begin
      r = v + count_t'(1);
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/cslex_in_reg.sv -----
// ----------------------------------------------------------------------------
// Input register
// Holds one accepted byte until the lexer core can take it; the core takes
// it whenever the result register is free or is being emptied.
// ----------------------------------------------------------------------------
module cslex_in_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  cslex_pkg::in_item_t in_data_i,
  input  logic               take_i,
  output logic               valid_o,
  output cslex_pkg::in_item_t item_o
);

  logic                valid_q, valid_d;
  cslex_pkg::in_item_t item_q;

  assign in_stall_o = valid_q && !take_i;
  assign valid_d    = in_valid_i || in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      item_q <= in_data_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ----- rtl/core/cslex_core.sv -----
// ----------------------------------------------------------------------------
// Lexer core
// Holds the lexer state and the saturating counters and works out, for one
// byte, the updated state and the result transaction carrying the counts.
// ----------------------------------------------------------------------------
module cslex_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 fire_i,
  input  cslex_pkg::in_item_t  item_i,
  output cslex_pkg::out_item_t result_o
);

  cslex_pkg::lex_mode_e mode_q, mode_d;
  logic [1:0] utf8_rem_q, utf8_rem_d;
  logic       in_mb_q, in_mb_d;
  logic       quote_q, quote_d;
  logic       esc_q, esc_d;
  logic       star_q, star_d;
  logic [2:0] id_len_q, id_len_d;
  logic [1:0] kw_q, kw_d;
  cslex_pkg::count_t lines_q, lines_d, chars_q, chars_d, spaces_q, spaces_d;
  cslex_pkg::count_t printf_q, printf_d, scanf_q, scanf_d, comments_q, comments_d;
  cslex_pkg::count_t lines_n, chars_n, spaces_n, printf_n, scanf_n, comments_n;

  logic [7:0] b;
  logic       other, is_sp, is_al, is_dg, alnum;
  logic       restart, need_top, kw_upd, id_finish;
  logic [2:0] kw_len;
  logic [1:0] kw_m;
  logic       inc_line, inc_char, inc_space, inc_printf, inc_scanf, inc_comment;
  logic [1:0] lead_rem;

  assign b = item_i.data_byte;

  always_comb begin
    mode_d      = mode_q;
    utf8_rem_d  = utf8_rem_q;
    in_mb_d     = in_mb_q;
    quote_d     = quote_q;
    esc_d       = esc_q;
    star_d      = star_q;
    id_len_d    = id_len_q;
    kw_d        = kw_q;
    restart     = 1'b0;
    need_top    = 1'b0;
    kw_upd      = 1'b0;
    id_finish   = 1'b0;
    kw_len      = id_len_q;
    kw_m        = kw_q;
    inc_line    = 1'b0;
    inc_char    = 1'b0;
    inc_space   = 1'b0;
    inc_comment = 1'b0;
    lead_rem    = 2'd0;

    priority if ((b & cslex_pkg::UTF8_MASK2) == cslex_pkg::UTF8_LEAD2) begin
      lead_rem = 2'd1;
    end else if ((b & cslex_pkg::UTF8_MASK3) == cslex_pkg::UTF8_LEAD3) begin
      lead_rem = 2'd2;
    end else if ((b & cslex_pkg::UTF8_MASK4) == cslex_pkg::UTF8_LEAD4) begin
      lead_rem = 2'd3;
    end else begin
      lead_rem = 2'd0;
    end

    // Any byte with the top bit set is classed as an ordinary, non-special character.
    other = b[7];
    is_sp = !other && (b == cslex_pkg::CH_SPACE || b == cslex_pkg::CH_CR ||
                       b == cslex_pkg::CH_LF || b == cslex_pkg::CH_TAB ||
                       b == cslex_pkg::CH_FF || b == cslex_pkg::CH_VT);
    is_al = !other && ((b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A));
    is_dg = !other && (b >= 8'h30 && b <= 8'h39);
    alnum = is_al || is_dg;

    if (item_i.end_marker) begin
      restart   = 1'b1;
      id_finish = (mode_q == cslex_pkg::MODE_IDENT);
    end else if (in_mb_q) begin
      utf8_rem_d = (utf8_rem_q != 2'd0) ? utf8_rem_q - 2'd1 : 2'd0;
      in_mb_d    = (utf8_rem_d != 2'd0);
    end else begin
      utf8_rem_d = lead_rem;
      in_mb_d    = (lead_rem != 2'd0);
      inc_space  = is_sp;
      inc_line   = is_sp && (b == cslex_pkg::CH_LF);
      inc_char   = !is_sp;

      unique case (mode_q)
        cslex_pkg::MODE_SLASH: begin
          if (!other && b == cslex_pkg::CH_SLASH) begin
            mode_d = cslex_pkg::MODE_LINE;
          end else if (!other && b == cslex_pkg::CH_STAR) begin
            mode_d      = cslex_pkg::MODE_BLOCK;
            star_d      = 1'b1;
            inc_comment = 1'b1;
          end else begin
            need_top = 1'b1;
          end
        end
        cslex_pkg::MODE_STRING: begin
          if (esc_q) begin
            esc_d = 1'b0;
          end else if (!other && b == cslex_pkg::CH_BSLASH) begin
            esc_d = 1'b1;
          end else if (!other && b == (quote_q ? cslex_pkg::CH_SQUOTE
                                               : cslex_pkg::CH_DQUOTE)) begin
            mode_d = cslex_pkg::MODE_TOP;
          end
        end
        cslex_pkg::MODE_LINE: begin
          if (!other && b == cslex_pkg::CH_LF) begin
            mode_d = cslex_pkg::MODE_TOP;
          end
        end
        cslex_pkg::MODE_BLOCK: begin
          if (star_q && !other && b == cslex_pkg::CH_SLASH) begin
            star_d = 1'b0;
            mode_d = cslex_pkg::MODE_TOP;
          end else begin
            star_d = !other && (b == cslex_pkg::CH_STAR);
          end
        end
        cslex_pkg::MODE_IDENT: begin
          if (alnum) begin
            kw_upd = 1'b1;
          end else begin
            id_finish = 1'b1;
            need_top  = 1'b1;
          end
        end
        cslex_pkg::MODE_NUMBER: begin
          if (!(is_dg || (!other && b == cslex_pkg::CH_DOT))) begin
            need_top = 1'b1;
          end
        end
        default: begin
          need_top = 1'b1;
        end
      endcase

      if (need_top) begin
        mode_d = cslex_pkg::MODE_TOP;
        if (!other && (b == cslex_pkg::CH_DQUOTE || b == cslex_pkg::CH_SQUOTE)) begin
          mode_d  = cslex_pkg::MODE_STRING;
          quote_d = (b == cslex_pkg::CH_SQUOTE);
          esc_d   = 1'b0;
        end else if (!other && b == cslex_pkg::CH_SLASH) begin
          mode_d = cslex_pkg::MODE_SLASH;
        end else if (is_al) begin
          mode_d = cslex_pkg::MODE_IDENT;
          kw_upd = 1'b1;
          kw_len = 3'd0;
          kw_m   = 2'b11;
        end else if (is_dg || (!other && b == cslex_pkg::CH_DOT)) begin
          mode_d = cslex_pkg::MODE_NUMBER;
        end
      end

      if (kw_upd) begin
        kw_d = kw_m;
        if (!(kw_len < cslex_pkg::PRINTF_LEN && b == cslex_pkg::printf_char(kw_len))) begin
          kw_d[0] = 1'b0;
        end
        if (!(kw_len < cslex_pkg::SCANF_LEN && b == cslex_pkg::scanf_char(kw_len))) begin
          kw_d[1] = 1'b0;
        end
        id_len_d = (kw_len < cslex_pkg::IDENT_MAX) ? kw_len + 3'd1 : kw_len;
      end
    end

    inc_printf = id_finish && (id_len_q == cslex_pkg::PRINTF_LEN) && kw_q[0];
    inc_scanf  = id_finish && !inc_printf && (id_len_q == cslex_pkg::SCANF_LEN) && kw_q[1];
  end

  assign lines_n    = cslex_pkg::sat_inc(lines_q, inc_line);
  assign chars_n    = cslex_pkg::sat_inc(chars_q, inc_char);
  assign spaces_n   = cslex_pkg::sat_inc(spaces_q, inc_space);
  assign printf_n   = cslex_pkg::sat_inc(printf_q, inc_printf);
  assign scanf_n    = cslex_pkg::sat_inc(scanf_q, inc_scanf);
  assign comments_n = cslex_pkg::sat_inc(comments_q, inc_comment);

  // End of file reports the final counts and then returns everything to reset.
  assign lines_d    = restart ? cslex_pkg::count_t'(1) : lines_n;
  assign chars_d    = restart ? '0 : chars_n;
  assign spaces_d   = restart ? '0 : spaces_n;
  assign printf_d   = restart ? '0 : printf_n;
  assign scanf_d    = restart ? '0 : scanf_n;
  assign comments_d = restart ? '0 : comments_n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= cslex_pkg::MODE_TOP;
      utf8_rem_q <= 2'd0;
      in_mb_q    <= 1'b0;
      quote_q    <= 1'b0;
      esc_q      <= 1'b0;
      star_q     <= 1'b0;
      id_len_q   <= 3'd0;
      kw_q       <= 2'b11;
      lines_q    <= cslex_pkg::count_t'(1);
      chars_q    <= '0;
      spaces_q   <= '0;
      printf_q   <= '0;
      scanf_q    <= '0;
      comments_q <= '0;
    end else if (fire_i) begin
      if (restart) begin
        mode_q     <= cslex_pkg::MODE_TOP;
        utf8_rem_q <= 2'd0;
        in_mb_q    <= 1'b0;
        quote_q    <= 1'b0;
        esc_q      <= 1'b0;
        star_q     <= 1'b0;
        id_len_q   <= 3'd0;
        kw_q       <= 2'b11;
      end else begin
        mode_q     <= mode_d;
        utf8_rem_q <= utf8_rem_d;
        in_mb_q    <= in_mb_d;
        quote_q    <= quote_d;
        esc_q      <= esc_d;
        star_q     <= star_d;
        id_len_q   <= id_len_d;
        kw_q       <= kw_d;
      end
      lines_q    <= lines_d;
      chars_q    <= chars_d;
      spaces_q   <= spaces_d;
      printf_q   <= printf_d;
      scanf_q    <= scanf_d;
      comments_q <= comments_d;
    end
  end

  assign result_o.line_count    = cslex_pkg::OUT_WIDTH'(lines_n);
  assign result_o.char_count    = cslex_pkg::OUT_WIDTH'(chars_n);
  assign result_o.space_count   = cslex_pkg::OUT_WIDTH'(spaces_n);
  assign result_o.printf_count  = cslex_pkg::OUT_WIDTH'(printf_n);
  assign result_o.scanf_count   = cslex_pkg::OUT_WIDTH'(scanf_n);
  assign result_o.comment_count = cslex_pkg::OUT_WIDTH'(comments_n);
  assign result_o.done_res      = restart;

endmodule

// ----- rtl/core/c_source_lexer_statistics_top.sv -----
// ----------------------------------------------------------------------------
// C source lexer statistics, top level
// Lexes a C source byte stream and returns running statistics for every byte.
// ----------------------------------------------------------------------------
// The accepting edge loads the input register; the result register is loaded
// when the byte moves on through the lexer core. Throughput: one byte per cycle,
// set by the single pass through the lexer core; the input stalls only while a
// result is held. Reset is asynchronous and active low; it empties both registers
// and returns the lexer and all counters to their start values.
module c_source_lexer_statistics_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  cslex_pkg::in_item_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output cslex_pkg::out_item_t out_data_o
);

  logic                 item_valid, fire;
  cslex_pkg::in_item_t  item;
  cslex_pkg::out_item_t result;
  logic                 out_valid_q, out_valid_d;
  cslex_pkg::out_item_t out_q;

  cslex_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .take_i     (fire),
    .valid_o    (item_valid),
    .item_o     (item)
  );

  // A byte moves on whenever the result register is empty or being drained.
  assign fire = item_valid && (!out_valid_q || !out_stall_i);

  cslex_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (item),
    .result_o (result)
  );

  assign out_valid_d = fire || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_eof_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && item.end_marker |=> out_valid_q && out_q.done_res)
    else $error("end-of-file transaction did not produce a done result");

  a_byte_not_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && !item.end_marker |=> out_valid_q && !out_q.done_res)
    else $error("data byte produced a done result");

  a_no_idle_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> !in_stall_o)
    else $error("input stalled while the result register was empty");

  a_eof_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && item.end_marker ##1 fire |=> out_q.line_count != '0)
    else $error("line count lost its start value after end of file");

endmodule

// ----- test/c_source_lexer_statistics_checker.sv -----
// ----------------------------------------------------------------------------
// C source lexer statistics checker
// Watches both channels of the lexer, keeps its own model of the lexer state
// and of the running counters, and compares every result transaction field by
// field against the oldest predicted counts.
// ----------------------------------------------------------------------------
module c_source_lexer_statistics_checker
  import cslex_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  in_item_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  out_item_t out_data_i,
  output int        fail_count_o,
  output int        pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Bytes of a multibyte sequence and stray high bytes lex as one neutral char.
  localparam logic [8:0]  NON_ASCII  = 9'h100;
  localparam logic [47:0] PRINTF_TXT = "printf";
  localparam logic [39:0] SCANF_TXT  = "scanf";

  lex_mode_e  mode;
  logic [1:0] utf_left;
  logic       utf_busy;
  logic       single_quote;
  logic       escaped;
  logic       star_open;
  logic [2:0] id_len;
  logic [1:0] kw_hit;   // bit 0: still printf, bit 1: still scanf
  count_t     n_lines;
  count_t     n_chars;
  count_t     n_spaces;
  count_t     n_printf;
  count_t     n_scanf;
  count_t     n_comments;

  out_item_t  expected_counts_q[$];
  out_item_t  want;
  int         fails = 0;

  function automatic count_t bump(count_t v);
    return (v == '1) ? v : v + count_t'(1);
  endfunction

  function automatic logic is_alpha(logic [8:0] c);
    return (c >= 9'h061 && c <= 9'h07A) || (c >= 9'h041 && c <= 9'h05A);
  endfunction

  function automatic logic is_digit(logic [8:0] c);
    return c >= 9'h030 && c <= 9'h039;
  endfunction

  function automatic logic is_blank(logic [8:0] c);
    return c == {1'b0, CH_SPACE} || c == {1'b0, CH_CR} || c == {1'b0, CH_LF} ||
           c == {1'b0, CH_TAB} || c == {1'b0, CH_FF} || c == {1'b0, CH_VT};
  endfunction

  function automatic void clear_lexer();
    mode         = MODE_TOP;
    utf_left     = 2'd0;
    utf_busy     = 1'b0;
    single_quote = 1'b0;
    escaped      = 1'b0;
    star_open    = 1'b0;
    id_len       = 3'd0;
    kw_hit       = 2'b11;
    n_lines      = count_t'(1);
    n_chars      = '0;
    n_spaces     = '0;
    n_printf     = '0;
    n_scanf      = '0;
    n_comments   = '0;
  endfunction

  function automatic void track_keyword(logic [8:0] c);
    int pos;
    pos = int'(id_len);
    if (pos >= 6 || c != {1'b0, PRINTF_TXT[47-8*pos -: 8]}) kw_hit[0] = 1'b0;
    if (pos >= 5 || c != {1'b0, SCANF_TXT[39-8*pos -: 8]}) kw_hit[1] = 1'b0;
    if (id_len != IDENT_MAX) id_len = id_len + 3'd1;
  endfunction

  function automatic void finish_word();
    if (id_len == PRINTF_LEN && kw_hit[0]) begin
      n_printf = bump(n_printf);
    end else if (id_len == SCANF_LEN && kw_hit[1]) begin
      n_scanf = bump(n_scanf);
    end
  endfunction

  function automatic void start_token(logic [8:0] c);
    mode = MODE_TOP;
    if (c == {1'b0, CH_DQUOTE} || c == {1'b0, CH_SQUOTE}) begin
      mode         = MODE_STRING;
      single_quote = (c == {1'b0, CH_SQUOTE});
      escaped      = 1'b0;
    end else if (c == {1'b0, CH_SLASH}) begin
      mode = MODE_SLASH;
    end else if (is_alpha(c)) begin
      mode   = MODE_IDENT;
      id_len = 3'd0;
      kw_hit = 2'b11;
      track_keyword(c);
    end else if (is_digit(c) || c == {1'b0, CH_DOT}) begin
      mode = MODE_NUMBER;
    end
  endfunction

  function automatic void advance_lexer(logic [8:0] c);
    case (mode)
      MODE_SLASH: begin
        if (c == {1'b0, CH_SLASH}) begin
          mode = MODE_LINE;
        end else if (c == {1'b0, CH_STAR}) begin
          // The opening star counts as a possible closing star as well.
          mode       = MODE_BLOCK;
          star_open  = 1'b1;
          n_comments = bump(n_comments);
        end else begin
          start_token(c);
        end
      end
      MODE_STRING: begin
        if (escaped) begin
          escaped = 1'b0;
        end else if (c == {1'b0, CH_BSLASH}) begin
          escaped = 1'b1;
        end else if (c == {1'b0, single_quote ? CH_SQUOTE : CH_DQUOTE}) begin
          mode = MODE_TOP;
        end
      end
      MODE_LINE: begin
        if (c == {1'b0, CH_LF}) mode = MODE_TOP;
      end
      MODE_BLOCK: begin
        if (star_open && c == {1'b0, CH_SLASH}) begin
          star_open = 1'b0;
          mode      = MODE_TOP;
        end else begin
          star_open = (c == {1'b0, CH_STAR});
        end
      end
      MODE_IDENT: begin
        if (is_alpha(c) || is_digit(c)) begin
          track_keyword(c);
        end else begin
          finish_word();
          start_token(c);
        end
      end
      MODE_NUMBER: begin
        if (!(is_digit(c) || c == {1'b0, CH_DOT})) start_token(c);
      end
      default: begin
        start_token(c);
      end
    endcase
  endfunction

  function automatic out_item_t counts_now(logic done);
    out_item_t r;
    r.line_count    = OUT_WIDTH'(n_lines);
    r.char_count    = OUT_WIDTH'(n_chars);
    r.space_count   = OUT_WIDTH'(n_spaces);
    r.printf_count  = OUT_WIDTH'(n_printf);
    r.scanf_count   = OUT_WIDTH'(n_scanf);
    r.comment_count = OUT_WIDTH'(n_comments);
    r.done_res      = done;
    return r;
  endfunction

  function automatic out_item_t lex_source_byte(in_item_t it);
    out_item_t  r;
    logic [7:0] b;
    logic [8:0] c;
    b = it.data_byte;
    if (it.end_marker) begin
      // End of file finishes a pending identifier; open strings and comments just end.
      if (mode == MODE_IDENT) finish_word();
      r = counts_now(1'b1);
      clear_lexer();
      return r;
    end
    if (utf_busy) begin
      if (utf_left != 2'd0) utf_left = utf_left - 2'd1;
      utf_busy = (utf_left != 2'd0);
    end else begin
      if ((b & UTF8_MASK2) == UTF8_LEAD2) begin
        utf_left = 2'd1;
      end else if ((b & UTF8_MASK3) == UTF8_LEAD3) begin
        utf_left = 2'd2;
      end else if ((b & UTF8_MASK4) == UTF8_LEAD4) begin
        utf_left = 2'd3;
      end else begin
        utf_left = 2'd0;
      end
      utf_busy = (utf_left != 2'd0);
      c = (utf_busy || b[7]) ? NON_ASCII : {1'b0, b};
      if (is_blank(c)) begin
        n_spaces = bump(n_spaces);
        if (c == {1'b0, CH_LF}) n_lines = bump(n_lines);
      end else begin
        n_chars = bump(n_chars);
      end
      advance_lexer(c);
    end
    return counts_now(1'b0);
  endfunction

  task automatic check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected %0d, actual %0d", name, want_v, got_v);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_lexer();
      expected_counts_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // Results come two stages after their input, so compare before pushing.
      if (out_valid_i && !out_stall_i) begin
        if (expected_counts_q.size() == 0) begin
          $error("result transaction with no expected counts waiting");
          fails++;
        end else begin
          want = expected_counts_q.pop_front();
          check_field("line_count", want.line_count, out_data_i.line_count);
          check_field("char_count", want.char_count, out_data_i.char_count);
          check_field("space_count", want.space_count, out_data_i.space_count);
          check_field("printf_count", want.printf_count, out_data_i.printf_count);
          check_field("scanf_count", want.scanf_count, out_data_i.scanf_count);
          check_field("comment_count", want.comment_count, out_data_i.comment_count);
          check_field("done_res", 32'(want.done_res), 32'(out_data_i.done_res));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        expected_counts_q.push_back(lex_source_byte(in_data_i));
      end
      fail_count_o <= fails;
      pending_o    <= expected_counts_q.size();
    end
  end

endmodule

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// C source lexer statistics testbench
// Feeds the lexer directed C fragments and then about a thousand bytes of
// random, mostly well-formed C text with noise, UTF-8 and end-of-file
// transactions, under random idling on both channels. A checker beside the
// block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cslex_pkg::*;

  localparam int RANDOM_ITEMS = 1000;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  int        fail_count;
  int        pending;

  logic       hold_req   = 1'b0;
  int         sent_count = 0;
  int         calm_left  = 0;
  logic       calm       = 1'b0;
  logic [7:0] frag_q[$];

  string near_words[9] = '{"printf", "scanf", "printfs", "scanf2", "print",
                           "scan", "Printf", "sscanf", "printf9"};

  c_source_lexer_statistics_top uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  c_source_lexer_statistics_checker lexer_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("c_source_lexer_statistics_top: mismatch");
    $finish;
  end

  // Sender idling comes in stretches: calm stretches send back to back.
  function automatic int pick_gap();
    int r;
    if (calm_left == 0) begin
      calm      = ($urandom_range(0, 2) == 0);
      calm_left = $urandom_range(10, 80);
    end
    calm_left--;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) frag_q.push_back(s[i]);
  endfunction

  function automatic logic [7:0] pick_char(string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  function automatic logic [7:0] rand_letter();
    logic [7:0] ch;
    ch = 8'h61 + 8'($urandom_range(0, 25));
    if ($urandom_range(0, 1) == 1) ch = ch - 8'h20;
    return ch;
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'h30 + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_print();
    return 8'($urandom_range(32, 126));
  endfunction

  // One C-like fragment with random content; a few are deliberately broken.
  function automatic void build_fragment();
    logic [7:0] quote;
    int         n;
    case ($urandom_range(0, 10))
      0: begin
        frag_q.push_back(rand_letter());
        repeat ($urandom_range(0, 8)) begin
          frag_q.push_back(($urandom_range(0, 2) == 0) ? rand_digit() : rand_letter());
        end
      end
      1: put_text(near_words[$urandom_range(0, 8)]);
      2: begin
        repeat ($urandom_range(1, 6)) begin
          frag_q.push_back(($urandom_range(0, 3) == 0) ? CH_DOT : rand_digit());
        end
      end
      3: begin
        repeat ($urandom_range(1, 4)) frag_q.push_back(pick_char(" \t\r\n\f\v"));
      end
      4: begin
        quote = ($urandom_range(0, 1) == 1) ? CH_SQUOTE : CH_DQUOTE;
        frag_q.push_back(quote);
        repeat ($urandom_range(0, 8)) begin
          n = $urandom_range(0, 5);
          if (n == 0) begin
            frag_q.push_back(CH_BSLASH);
            frag_q.push_back(rand_print());
          end else if (n == 1) begin
            frag_q.push_back((quote == CH_SQUOTE) ? CH_DQUOTE : CH_SQUOTE);
          end else begin
            frag_q.push_back(rand_print());
          end
        end
        if ($urandom_range(0, 7) != 0) frag_q.push_back(quote);
      end
      5: begin
        put_text("//");
        repeat ($urandom_range(0, 10)) frag_q.push_back(rand_print());
        if ($urandom_range(0, 5) != 0) frag_q.push_back(CH_LF);
      end
      6: begin
        if ($urandom_range(0, 3) == 0) begin
          put_text("/*/");
        end else begin
          put_text("/*");
          repeat ($urandom_range(0, 8)) frag_q.push_back(pick_char("*/ a\n*x"));
          put_text("*/");
        end
      end
      7: begin
        n = $urandom_range(1, 3);
        if (n == 1) begin
          frag_q.push_back(8'hC0 | 8'($urandom_range(0, 31)));
        end else if (n == 2) begin
          frag_q.push_back(8'hE0 | 8'($urandom_range(0, 15)));
        end else begin
          frag_q.push_back(8'hF0 | 8'($urandom_range(0, 7)));
        end
        // A short sequence lets the next fragment's bytes be absorbed.
        if ($urandom_range(0, 5) == 0) n = n - 1;
        repeat (n) frag_q.push_back(8'h80 | 8'($urandom_range(0, 63)));
      end
      8: frag_q.push_back(pick_char("(){};,+-=<>*&!%/#[]"));
      9: begin
        repeat ($urandom_range(1, 4)) frag_q.push_back(8'($urandom_range(0, 255)));
      end
      default: frag_q.push_back(CH_LF);
    endcase
  endfunction

  task automatic send_item(logic [7:0] b, logic eof);
    int gap;
    in_valid <= 1'b1;
    in_data  <= '{data_byte: b, end_marker: eof};
    do @(posedge clk); while (in_stall);
    sent_count++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_fragment();
    while (frag_q.size() > 0) send_item(frag_q.pop_front(), 1'b0);
  endtask

  task automatic drain_results();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Receiver: stretches without stalls, light and heavy stalling, and the
  // occasional long hold-off counted here.
  initial begin
    int hold_left;
    int burst_left;
    int mode_sel;
    hold_left  = 0;
    burst_left = 0;
    mode_sel   = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 64;
      end
      if (burst_left == 0) begin
        mode_sel   = $urandom_range(0, 2);
        burst_left = $urandom_range(10, 60);
      end
      burst_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (mode_sel == 0) begin
        out_stall <= 1'b0;
      end else if (mode_sel == 1) begin
        out_stall <= ($urandom_range(0, 3) == 0);
      end else begin
        if ($urandom_range(0, 59) == 0) hold_left = $urandom_range(10, 30);
        out_stall <= ($urandom_range(0, 1) == 0);
      end
    end
  end

  initial begin
    int   rand_start;
    logic held;
    logic paused;
    held   = 1'b0;
    paused = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Keyword ended by a slash operator, a number, a comment closed by its
    // opening star, a string with an escaped quote, extreme and stray bytes,
    // a three-byte character, then a sequence cut short by end of file.
    put_text("printf/./*/\"\\\"\"");
    frag_q.push_back(8'h00);
    frag_q.push_back(8'hFF);
    frag_q.push_back(8'hE2);
    frag_q.push_back(8'h82);
    frag_q.push_back(8'hAC);
    frag_q.push_back(8'hF0);
    send_fragment();
    send_item(8'hFF, 1'b1);
    // An identifier still pending at end of file.
    put_text("scanf");
    send_fragment();
    send_item(8'h00, 1'b1);

    rand_start = sent_count;
    while (sent_count - rand_start < RANDOM_ITEMS) begin
      if (!held && sent_count - rand_start >= 300) begin
        held     = 1'b1;
        hold_req = 1'b1;
      end
      if (!paused && sent_count - rand_start >= 600) begin
        paused = 1'b1;
        in_valid <= 1'b0;
        drain_results();
      end
      if ($urandom_range(0, 39) == 0) begin
        send_item(8'($urandom_range(0, 255)), 1'b1);
      end else begin
        build_fragment();
        send_fragment();
      end
    end
    in_valid <= 1'b0;
    drain_results();
    repeat (8) @(posedge clk);

    if (fail_count == 0) begin
      $display("c_source_lexer_statistics_top: match");
    end else begin
      $display("c_source_lexer_statistics_top: mismatch");
    end
    $finish;
  end

endmodule
